>>> rtl/tnau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnau_pkg
// Shared widths and the square root unit status record.
// ----------------------------------------------------------------------------
package tnau_pkg;

	localparam int ROOT_W = 52;            // root bits of the square root unit
	localparam int RAD_W  = 2 * ROOT_W;    // radicand bits
	localparam int COORD_W = 24;           // Q16.8 coordinate
	localparam int VERT_W  = 3 * COORD_W;  // one packed vertex {x, y, z}

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [ROOT_W-1:0] root;
	} sqrt_stat_t;

endpackage

>>> rtl/tnau_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnau_sqrt
// Restoring integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module tnau_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [tnau_pkg::RAD_W-1:0]    radicand,
	output tnau_pkg::sqrt_stat_t          stat
);

	localparam int RW = tnau_pkg::ROOT_W;
	localparam int CNT_W = $clog2(RW);

	logic [tnau_pkg::RAD_W-1:0] rad_q;
	logic [RW:0]                rem_q;
	logic [RW-1:0]              root_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;

	logic [RW+2:0] rem_n;
	logic [RW+2:0] trial;
	logic [RW+2:0] diff;

	assign rem_n = {rem_q, rad_q[tnau_pkg::RAD_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign diff  = rem_n - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(RW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: take two radicand bits, try the next root bit.
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[tnau_pkg::RAD_W-3:0], 2'b00};
			if (rem_n >= trial) begin
				rem_q  <= diff[RW:0];
				root_q <= {root_q[RW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_n[RW:0];
				root_q <= {root_q[RW-2:0], 1'b0};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign stat.root = root_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start) else $error("square root restarted while busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("done without a running root");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q <= {root_q, 1'b0}) else $error("remainder above twice root");

endmodule

>>> rtl/triangle_normal_and_area_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_normal_and_area_unit
// Vertex store plus face unit: cross product, area, unit normal, total area.
// ----------------------------------------------------------------------------
// Vertex write: no result. Face: the time from transfer to result is set by
// two 52-step square roots (one root bit per cycle), three 17-step divides
// and the one-bit-per-cycle normalizing shift, plus any output stall; a zero
// cross product skips the shift, the second root and the divides.
// One face in flight at a time; the next input transfers once the result
// sits in the output register. arst_n clears control, the running total and
// the output valid; the vertex store holds no reset value.
// ----------------------------------------------------------------------------
module triangle_normal_and_area_unit #(
	parameter int MAX_VERTICES = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  logic [11:0]        vertex_index,
	input  logic signed [23:0] coord_x,
	input  logic signed [23:0] coord_y,
	input  logic signed [23:0] coord_z,
	input  logic [11:0]        corner_a,
	input  logic [11:0]        corner_b,
	input  logic [11:0]        corner_c,
	input  logic               first_face,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic [51:0]        face_area,
	output logic [62:0]        total_area
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int CW = (AW > 12) ? AW : 12;
	localparam logic [CW:0] MAXV = (CW+1)'(MAX_VERTICES);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_RDA  = 5'd1;
	localparam logic [4:0] S_RDB  = 5'd2;
	localparam logic [4:0] S_RDC  = 5'd3;
	localparam logic [4:0] S_EDGE = 5'd4;
	localparam logic [4:0] S_XP   = 5'd5;
	localparam logic [4:0] S_MAG  = 5'd6;
	localparam logic [4:0] S_SQ   = 5'd7;
	localparam logic [4:0] S_SQS1 = 5'd8;
	localparam logic [4:0] S_SQW1 = 5'd9;
	localparam logic [4:0] S_NORM = 5'd10;
	localparam logic [4:0] S_SQ2  = 5'd11;
	localparam logic [4:0] S_SQS2 = 5'd12;
	localparam logic [4:0] S_SQW2 = 5'd13;
	localparam logic [4:0] S_DLD  = 5'd14;
	localparam logic [4:0] S_DIV  = 5'd15;
	localparam logic [4:0] S_DST  = 5'd16;
	localparam logic [4:0] S_FIN  = 5'd17;

	// Pull one signed coordinate (0 = x, 1 = y, 2 = z) out of a packed vertex.
	function automatic logic signed [24:0] coord(input logic [tnau_pkg::VERT_W-1:0] v,
		input logic [1:0] k);
		logic [23:0] c;
		begin
			case (k)
				2'd0:    c = v[71:48];
				2'd1:    c = v[47:24];
				default: c = v[23:0];
			endcase
			coord = $signed({c[23], c});
		end
	endfunction

	// Vertex store: one write port, one registered read port.
	logic [tnau_pkg::VERT_W-1:0] mem [MAX_VERTICES];
	logic [tnau_pkg::VERT_W-1:0] rd_q;
	logic [AW-1:0]               rd_addr;
	logic                        wr_en;
	logic [CW-1:0]               vidx_ext;

	logic [4:0]  state_q;
	logic [11:0] ca_q, cb_q, cc_q;
	logic [2:0]  ok_q;
	logic        first_q;
	logic [tnau_pkg::VERT_W-1:0] pa_q, pb_q;

	logic signed [24:0] e1_q [3];
	logic signed [24:0] e2_q [3];
	logic signed [50:0] n_q  [3];
	logic [49:0]        mag_q [3];
	logic [2:0]         neg_q;
	logic [49:0]        mx_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod_q;
	logic [99:0]        l2_q;
	logic [63:0]        l2s_q;
	logic [99:0]        sq_term;

	logic [2:0]  step_q;
	logic [1:0]  part_q;
	logic [1:0]  comp_q;
	logic        ph_q;
	logic [4:0]  cnt_q;

	logic [31:0] len_q;
	logic [16:0] nlo_q;
	logic [32:0] rem_q;
	logic [16:0] quo_q;
	logic [46:0] num;
	logic [32:0] drem_n;

	logic [50:0] area_q;
	logic [62:0] sum_q;
	logic [63:0] sum_n;
	logic [15:0] nrm_q [3];
	logic        out_valid_q;
	logic [15:0] onx_q, ony_q, onz_q;
	logic [51:0] oarea_q;
	logic [62:0] ototal_q;

	logic                          sq_start;
	logic [tnau_pkg::RAD_W-1:0]    sq_rad;
	tnau_pkg::sqrt_stat_t          sq_stat;
	logic [49:0]                   mx_n;
	logic                          in_xfer;

	function automatic logic in_range(input logic [11:0] idx);
		in_range = {1'b0, CW'(idx)} < MAXV;
	endfunction

	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign vidx_ext = CW'(vertex_index);
	assign wr_en    = in_xfer && !action && in_range(vertex_index);

	always_comb begin
		unique case (state_q)
			S_RDA:   rd_addr = AW'(CW'(ca_q));
			S_RDB:   rd_addr = AW'(CW'(cb_q));
			default: rd_addr = AW'(CW'(cc_q));
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[AW'(vidx_ext)] <= {coord_x, coord_y, coord_z};
		rd_q <= mem[rd_addr];
	end

	// Shared multiplier operands, picked by the sequencer position.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_XP: begin
				case (step_q)
					3'd0: begin mul_a = 33'(e1_q[1]); mul_b = 33'(e2_q[2]); end
					3'd1: begin mul_a = 33'(e1_q[2]); mul_b = 33'(e2_q[1]); end
					3'd2: begin mul_a = 33'(e1_q[2]); mul_b = 33'(e2_q[0]); end
					3'd3: begin mul_a = 33'(e1_q[0]); mul_b = 33'(e2_q[2]); end
					3'd4: begin mul_a = 33'(e1_q[0]); mul_b = 33'(e2_q[1]); end
					default: begin mul_a = 33'(e1_q[1]); mul_b = 33'(e2_q[0]); end
				endcase
			end
			S_SQ: begin
				case (part_q)
					2'd0: begin
						mul_a = $signed({8'd0, mag_q[comp_q][24:0]});
						mul_b = $signed({8'd0, mag_q[comp_q][24:0]});
					end
					2'd1: begin
						mul_a = $signed({8'd0, mag_q[comp_q][49:25]});
						mul_b = $signed({8'd0, mag_q[comp_q][24:0]});
					end
					default: begin
						mul_a = $signed({8'd0, mag_q[comp_q][49:25]});
						mul_b = $signed({8'd0, mag_q[comp_q][49:25]});
					end
				endcase
			end
			S_SQ2: begin
				mul_a = $signed({2'd0, mag_q[comp_q][30:0]});
				mul_b = $signed({2'd0, mag_q[comp_q][30:0]});
			end
			default: ;
		endcase
	end

	// Place the partial square: low*low, 2*high*low, high*high.
	always_comb begin
		case (part_q)
			2'd0:    sq_term = {50'd0, prod_q[49:0]};
			2'd1:    sq_term = {50'd0, prod_q[49:0]} << 26;
			default: sq_term = {50'd0, prod_q[49:0]} << 50;
		endcase
	end

	always_comb begin
		mx_n = mag_q[0];
		if (mag_q[1] > mx_n) mx_n = mag_q[1];
		if (mag_q[2] > mx_n) mx_n = mag_q[2];
	end

	// Rounded dividend: mag * 2^15 + len / 2.
	assign num    = {1'b0, mag_q[comp_q][30:0], 15'd0} + {16'd0, len_q[31:1]};
	assign drem_n = {rem_q[31:0], nlo_q[16]};

	assign sq_start = (state_q == S_SQS1) || (state_q == S_SQS2);
	assign sq_rad   = (state_q == S_SQS2) ? {l2s_q, 40'd0} : {4'd0, l2_q};

	tnau_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (sq_rad),
		.stat     (sq_stat)
	);

	// Saturating running total; first face restarts from zero.
	assign sum_n = {1'b0, (first_q ? 63'd0 : sum_q)} + {13'd0, area_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			part_q      <= '0;
			comp_q      <= '0;
			ph_q        <= 1'b0;
			cnt_q       <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Drop the result after its transfer unless a new one loads now.
			if (out_valid_q && out_ready && state_q != S_FIN)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_xfer && action) state_q <= S_RDA;
				S_RDA:  state_q <= S_RDB;
				S_RDB:  state_q <= S_RDC;
				S_RDC:  state_q <= S_EDGE;
				S_EDGE: begin
					state_q <= S_XP;
					step_q  <= '0;
					ph_q    <= 1'b0;
				end
				S_XP: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						step_q <= step_q + 1'b1;
						if (step_q == 3'd5) state_q <= S_MAG;
					end
				end
				S_MAG: begin
					state_q <= S_SQ;
					comp_q  <= '0;
					part_q  <= '0;
					ph_q    <= 1'b0;
				end
				S_SQ: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (part_q == 2'd2) begin
							part_q <= '0;
							comp_q <= comp_q + 1'b1;
							if (comp_q == 2'd2) state_q <= S_SQS1;
						end else begin
							part_q <= part_q + 1'b1;
						end
					end
				end
				S_SQS1: state_q <= S_SQW1;
				S_SQW1: if (sq_stat.done) state_q <= (mx_n == '0) ? S_FIN : S_NORM;
				S_NORM: begin
					if (mx_q[49:31] == '0 && mx_q[30]) begin
						state_q <= S_SQ2;
						comp_q  <= '0;
						ph_q    <= 1'b0;
					end
				end
				S_SQ2: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						comp_q <= comp_q + 1'b1;
						if (comp_q == 2'd2) state_q <= S_SQS2;
					end
				end
				S_SQS2: state_q <= S_SQW2;
				S_SQW2: begin
					if (sq_stat.done) begin
						state_q <= S_DLD;
						comp_q  <= '0;
					end
				end
				S_DLD: begin
					state_q <= S_DIV;
					cnt_q   <= '0;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'd16) state_q <= S_DST;
				end
				S_DST: begin
					comp_q  <= comp_q + 1'b1;
					state_q <= (comp_q == 2'd2) ? S_FIN : S_DLD;
				end
				S_FIN: begin
					// Hold until the output register is free.
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						sum_q       <= sum_n[63] ? '1 : sum_n[62:0];
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			S_IDLE: begin
				if (in_xfer && action) begin
					ca_q    <= corner_a;
					cb_q    <= corner_b;
					cc_q    <= corner_c;
					ok_q    <= {in_range(corner_c), in_range(corner_b), in_range(corner_a)};
					first_q <= first_face;
				end
			end
			S_RDB: pa_q <= ok_q[0] ? rd_q : '0;
			S_RDC: pb_q <= ok_q[1] ? rd_q : '0;
			S_EDGE: begin
				for (int k = 0; k < 3; k++) begin
					e1_q[k] <= coord(pb_q, 2'(k)) - coord(pa_q, 2'(k));
					e2_q[k] <= coord(ok_q[2] ? rd_q : '0, 2'(k)) - coord(pa_q, 2'(k));
				end
			end
			S_XP: begin
				if (ph_q) begin
					if (!step_q[0])
						n_q[step_q[2:1]] <= $signed(prod_q[50:0]);
					else
						n_q[step_q[2:1]] <= n_q[step_q[2:1]] - $signed(prod_q[50:0]);
				end
			end
			S_MAG: begin
				for (int k = 0; k < 3; k++) begin
					neg_q[k] <= n_q[k][50];
					mag_q[k] <= n_q[k][50] ? 50'(-n_q[k]) : n_q[k][49:0];
				end
				l2_q <= '0;
			end
			S_SQ: if (ph_q) l2_q <= l2_q + sq_term;
			S_SQW1: begin
				if (sq_stat.done) begin
					area_q <= sq_stat.root[51:1];
					mx_q   <= mx_n;
					for (int k = 0; k < 3; k++) nrm_q[k] <= '0;
				end
				l2s_q <= '0;
			end
			S_NORM: begin
				// Step all magnitudes together until the largest sits in [2^30, 2^31).
				if (mx_q[49:31] != '0) begin
					mx_q <= mx_q >> 1;
					for (int k = 0; k < 3; k++) mag_q[k] <= mag_q[k] >> 1;
				end else if (!mx_q[30]) begin
					mx_q <= mx_q << 1;
					for (int k = 0; k < 3; k++) mag_q[k] <= mag_q[k] << 1;
				end
			end
			S_SQ2: if (ph_q) l2s_q <= l2s_q + prod_q[63:0];
			S_SQW2: if (sq_stat.done) len_q <= sq_stat.root[51:20];
			S_DLD: begin
				rem_q <= {3'd0, num[46:17]};
				nlo_q <= num[16:0];
				quo_q <= '0;
			end
			S_DIV: begin
				nlo_q <= {nlo_q[15:0], 1'b0};
				if (drem_n >= {1'b0, len_q}) begin
					rem_q <= drem_n - {1'b0, len_q};
					quo_q <= {quo_q[15:0], 1'b1};
				end else begin
					rem_q <= drem_n;
					quo_q <= {quo_q[15:0], 1'b0};
				end
			end
			S_DST: begin
				// Apply the sign, clip to the Q1.15 range.
				if (neg_q[comp_q])
					nrm_q[comp_q] <= (quo_q > 17'd32768) ? 16'h8000 : 16'(-quo_q);
				else
					nrm_q[comp_q] <= (quo_q > 17'd32767) ? 16'h7FFF : quo_q[15:0];
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					onx_q    <= nrm_q[0];
					ony_q    <= nrm_q[1];
					onz_q    <= nrm_q[2];
					oarea_q  <= {1'b0, area_q};
					ototal_q <= sum_n[63] ? '1 : sum_n[62:0];
				end
			end
			default: ;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign normal_x   = $signed(onx_q);
	assign normal_y   = $signed(ony_q);
	assign normal_z   = $signed(onz_q);
	assign face_area  = oarea_q;
	assign total_area = ototal_q;

	a_root_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sq_stat.done |-> (state_q == S_SQW1 || state_q == S_SQW2))
		else $error("square root finished outside a wait state");

	a_face_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && action) |=> !in_ready)
		else $error("input taken while a face is in work");

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SQ2) |-> (mx_q[49:31] == '0 && mx_q[30]))
		else $error("magnitudes not normalized");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < {1'b0, len_q}))
		else $error("divide remainder not below divisor");

endmodule
